[design/aus_pkg.sv]
// ----------------------------------------------------------------------------
// aus_pkg
// Shared types and constants of the Annex B access unit splitter.
// ----------------------------------------------------------------------------
package aus_pkg;

    localparam logic [7:0] CODEC_H264 = 8'h1C;
    localparam logic [7:0] CODEC_H265 = 8'hAE;

    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;

    localparam logic [4:0] H264_TYPE_SLICE = 5'd1;
    localparam logic [4:0] H264_TYPE_IDR   = 5'd5;
    localparam logic [4:0] H264_TYPE_SEI   = 5'd6;

    localparam logic [7:0] H265_HDR_TRAIL = 8'h02;
    localparam logic [7:0] H265_HDR_IDR   = 8'h26;

    // bytes held back for lookahead
    localparam int         WIN_HELD   = 5;
    localparam int         FILL_W     = 3;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_HELD);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
        logic       key_frame;
    } t_result;

    typedef struct packed {
        logic    wr_en;
        t_result data;
    } t_queue_wr;

endpackage

[design/aus_front.sv]
// ----------------------------------------------------------------------------
// aus_front
// Lookahead window, start code detection and unit classification.
// ----------------------------------------------------------------------------
module aus_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_data_byte,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    output aus_pkg::t_queue_wr o_wr
);

    logic [7:0]                 r_win [aus_pkg::WIN_HELD];
    logic [7:0]                 n_win [aus_pkg::WIN_HELD];
    logic [aus_pkg::FILL_W-1:0] r_fill;
    logic [aus_pkg::FILL_W-1:0] n_fill;
    logic [7:0]                 r_video_codec;
    logic                       r_seen, n_seen;
    logic                       r_drop, n_drop;
    logic                       r_end, n_end;
    logic                       r_key, n_key;
    logic                       win_full;
    logic                       sc0;
    logic                       sc1;
    logic                       last;

    assign win_full = (r_fill == aus_pkg::FILL_FULL);

    assign sc0 = (r_win[0] == aus_pkg::SC_ZERO) && (r_win[1] == aus_pkg::SC_ZERO) &&
                 (r_win[2] == aus_pkg::SC_ZERO) && (r_win[3] == aus_pkg::SC_ONE);
    assign sc1 = (r_win[1] == aus_pkg::SC_ZERO) && (r_win[2] == aus_pkg::SC_ZERO) &&
                 (r_win[3] == aus_pkg::SC_ZERO) && (r_win[4] == aus_pkg::SC_ONE);

    always_comb begin
        for (int k = 0; k < aus_pkg::WIN_HELD - 1; k++) begin
            n_win[k] = r_win[k+1];
        end
        n_win[aus_pkg::WIN_HELD-1] = i_data_byte;
    end

    always_comb begin
        n_fill = r_fill;
        if (!win_full) begin
            n_fill = r_fill + 1'b1;
        end
    end

    // header byte r_win[4] is in view when the start code is oldest
    always_comb begin
        n_seen = r_seen;
        n_drop = r_drop;
        n_end  = r_end;
        n_key  = r_key;
        if (win_full && sc0) begin
            n_seen = 1'b1;
            n_drop = 1'b0;
            n_end  = 1'b0;
            n_key  = 1'b0;
            if (r_video_codec == aus_pkg::CODEC_H264) begin
                unique case (r_win[4][4:0])
                    aus_pkg::H264_TYPE_SEI: begin
                        n_drop = 1'b1;
                    end
                    aus_pkg::H264_TYPE_SLICE: begin
                        n_end = 1'b1;
                    end
                    aus_pkg::H264_TYPE_IDR: begin
                        n_end = 1'b1;
                        n_key = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end else if (r_video_codec == aus_pkg::CODEC_H265) begin
                unique case (r_win[4])
                    aus_pkg::H265_HDR_TRAIL: begin
                        n_end = 1'b1;
                    end
                    aus_pkg::H265_HDR_IDR: begin
                        n_end = 1'b1;
                        n_key = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign last = n_end && sc1;

    always_comb begin
        o_wr.wr_en           = i_accept && win_full && n_seen && !n_drop;
        o_wr.data.frame_byte = r_win[0];
        o_wr.data.frame_end  = last;
        o_wr.data.key_frame  = last && n_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill        <= '0;
            r_video_codec <= '0;
            r_seen        <= 1'b0;
            r_drop        <= 1'b0;
            r_end         <= 1'b0;
            r_key         <= 1'b0;
            for (int k = 0; k < aus_pkg::WIN_HELD; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_video_codec <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_fill <= n_fill;
                r_seen <= n_seen;
                r_drop <= n_drop;
                r_end  <= n_end;
                r_key  <= n_key;
                for (int k = 0; k < aus_pkg::WIN_HELD; k++) begin
                    r_win[k] <= n_win[k];
                end
            end
        end
    end

endmodule

[design/aus_queue.sv]
// ----------------------------------------------------------------------------
// aus_queue
// Short result queue between the classifier and the output port.
// ----------------------------------------------------------------------------
module aus_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  aus_pkg::t_queue_wr i_wr,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_empty,
    output aus_pkg::t_result   o_data
);

    aus_pkg::t_result             r_mem [aus_pkg::QUEUE_DEPTH];
    logic [aus_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [aus_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [aus_pkg::QUEUE_CW-1:0] r_count;
    logic [aus_pkg::QUEUE_CW-1:0] n_count;
    logic                         do_pop;

    assign o_full  = (r_count == aus_pkg::QUEUE_CW'(aus_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (i_wr.wr_en && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr.wr_en && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_en) begin
            r_mem[r_wr_ptr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_wr.wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

[design/annexb_access_unit_splitter.sv]
// ----------------------------------------------------------------------------
// annexb_access_unit_splitter
// Annex B start code parser that passes kept bytes and marks frame ends.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock when push is high and full is low. Each
// byte comes out five bytes later (once its lookahead is in view), unless it
// precedes the first 00 00 00 01 start code or belongs to a dropped H.264 SEI
// unit; a slice unit's last byte carries frame_end (and key_frame if IDR).
// The last five bytes stay held until more input arrives. A four-entry result
// queue sits before the output; full rises only when four results wait, so
// with pop held high the block sustains one byte per clock. Write video_codec
// through i_cfg_wr_en / i_cfg_wr_data only while idle; it is not checked.
module annexb_access_unit_splitter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_frame_byte,
    output logic       o_frame_end,
    output logic       o_key_frame,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data
);

    aus_pkg::t_queue_wr queue_wr;
    aus_pkg::t_result   queue_data;
    logic               accept;

    assign accept = push && !full;

    aus_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .o_wr         (queue_wr)
    );

    aus_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (queue_wr),
        .i_pop  (pop),
        .o_full (full),
        .o_empty(empty),
        .o_data (queue_data)
    );

    assign o_frame_byte = queue_data.frame_byte;
    assign o_frame_end  = queue_data.frame_end;
    assign o_key_frame  = queue_data.key_frame;

endmodule

[tb/annexb_access_unit_splitter_checker.sv]
// ----------------------------------------------------------------------------
// annexb_access_unit_splitter_checker
// Watches the request and result channels of the splitter, predicts each
// kept byte with its frame-end and key flags, and counts mismatches.
// ----------------------------------------------------------------------------
// Every accepted stream byte goes through a copy of the six-byte lookahead
// window, the start code search and the unit classification under the
// codec that was last written. The results it yields queue up in order and
// each popped result is compared field by field with the oldest of them.
module annexb_access_unit_splitter_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_data_byte,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic [7:0] i_frame_byte,
    input  logic       i_frame_end,
    input  logic       i_key_frame,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_SLOTS = aus_pkg::WIN_HELD + 1;

    logic [7:0]       codec;
    logic [7:0]       win [WIN_SLOTS];
    int unsigned      win_fill;
    bit               seen_start;
    bit               unit_dropped;
    bit               unit_ends_frame;
    bit               unit_is_key;
    aus_pkg::t_result bytes_due [$];
    int               fails = 0;

    function automatic bit start_code_at(int p);
        return win[p] == aus_pkg::SC_ZERO && win[p+1] == aus_pkg::SC_ZERO &&
               win[p+2] == aus_pkg::SC_ZERO && win[p+3] == aus_pkg::SC_ONE;
    endfunction

    // shift one stream byte through the lookahead window
    task automatic advance_window(input logic [7:0] b);
        aus_pkg::t_result r;
        bit               last;
        if (win_fill > aus_pkg::WIN_HELD) win_fill = aus_pkg::WIN_HELD;
        win[win_fill] = b;
        win_fill++;
        if (win_fill < WIN_SLOTS) return;

        if (start_code_at(0)) begin
            seen_start      = 1'b1;
            unit_dropped    = 1'b0;
            unit_ends_frame = 1'b0;
            unit_is_key     = 1'b0;
            if (codec == aus_pkg::CODEC_H264) begin
                case (win[4][4:0]) inside
                    aus_pkg::H264_TYPE_SEI: unit_dropped = 1'b1;
                    aus_pkg::H264_TYPE_SLICE, aus_pkg::H264_TYPE_IDR: begin
                        unit_ends_frame = 1'b1;
                        unit_is_key     = (win[4][4:0] == aus_pkg::H264_TYPE_IDR);
                    end
                    default: ;
                endcase
            end else if (codec == aus_pkg::CODEC_H265) begin
                if (win[4] == aus_pkg::H265_HDR_TRAIL || win[4] == aus_pkg::H265_HDR_IDR) begin
                    unit_ends_frame = 1'b1;
                    unit_is_key     = (win[4] == aus_pkg::H265_HDR_IDR);
                end
            end
        end

        if (seen_start && !unit_dropped) begin
            last         = unit_ends_frame && start_code_at(1);
            r.frame_byte = win[0];
            r.frame_end  = last;
            r.key_frame  = last && unit_is_key;
            bytes_due.push_back(r);
        end

        for (int i = 0; i < aus_pkg::WIN_HELD; i++) win[i] = win[i+1];
        win[aus_pkg::WIN_HELD] = 8'h00;
        win_fill               = aus_pkg::WIN_HELD;
    endtask

    always @(posedge i_clk) begin : watch
        aus_pkg::t_result want;
        if (!i_rst_n) begin
            codec           = 8'h00;
            for (int i = 0; i < WIN_SLOTS; i++) win[i] = 8'h00;
            win_fill        = 0;
            seen_start      = 1'b0;
            unit_dropped    = 1'b0;
            unit_ends_frame = 1'b0;
            unit_is_key     = 1'b0;
            bytes_due.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (bytes_due.size() == 0) begin
                    $error("unexpected result: frame_byte %02h frame_end %0b key_frame %0b",
                           i_frame_byte, i_frame_end, i_key_frame);
                    fails++;
                end else begin
                    want = bytes_due.pop_front();
                    if (i_frame_byte !== want.frame_byte) begin
                        $error("frame_byte: expected %02h, got %02h",
                               want.frame_byte, i_frame_byte);
                        fails++;
                    end
                    if (i_frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0b, got %0b",
                               want.frame_end, i_frame_end);
                        fails++;
                    end
                    if (i_key_frame !== want.key_frame) begin
                        $error("key_frame: expected %0b, got %0b",
                               want.key_frame, i_key_frame);
                        fails++;
                    end
                end
            end
            if (i_cfg_wr_en) codec = i_cfg_wr_data;
            if (i_push && !i_full) advance_window(i_data_byte);
        end
        o_fail_count <= fails;
        o_pending    <= bytes_due.size();
    end

endmodule

[tb/annexb_access_unit_splitter_tb.sv]
// ----------------------------------------------------------------------------
// annexb_access_unit_splitter_tb
// Stimulus and verdict for the Annex B access unit splitter.
// ----------------------------------------------------------------------------
// Runs a short directed H.264 stream, then phases of random Annex B units
// (slices, IDR, SEI, other headers, false and broken start codes, noise)
// under H.264, H.265 and unknown codec settings. Both sides idle at random;
// one phase stalls the output long enough to back up the input. The
// checker beside the block predicts and compares every result.
module annexb_access_unit_splitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 500000;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int DRAIN_CYCLES   = 20;
    localparam int HOLD_CYCLES    = 300;
    localparam int PRESSURE_BYTES = 80;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       push          = 1'b0;
    logic [7:0] i_data_byte   = 8'h00;
    logic       pop           = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'h00;
    logic       full;
    logic       empty;
    logic [7:0] o_frame_byte;
    logic       o_frame_end;
    logic       o_key_frame;
    int         fail_count;
    int         pending;

    bit         tx_burst;
    bit         rx_hold_req;
    int         bytes_sent;
    logic [7:0] directed_bytes [$];
    logic [7:0] phase_codec [8];

    always #5 i_clk = ~i_clk;

    annexb_access_unit_splitter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_data_byte  (i_data_byte),
        .empty        (empty),
        .pop          (pop),
        .o_frame_byte (o_frame_byte),
        .o_frame_end  (o_frame_end),
        .o_key_frame  (o_key_frame),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    annexb_access_unit_splitter_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_data_byte  (i_data_byte),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_frame_byte (o_frame_byte),
        .i_frame_end  (o_frame_end),
        .i_key_frame  (o_key_frame),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (full);
        bytes_sent++;
    endtask

    task automatic send_start_code(input logic [7:0] hdr);
        if ($urandom_range(0, 5) == 0) send_byte(aus_pkg::SC_ZERO);
        repeat (3) send_byte(aus_pkg::SC_ZERO);
        send_byte(aus_pkg::SC_ONE);
        send_byte(hdr);
    endtask

    // hold off until every expected result has come, then let the window settle
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_codec(input logic [7:0] v);
        i_cfg_wr_data <= v;
        i_cfg_wr_en   <= 1'b1;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_random_unit();
        logic [7:0] hdr;
        int         len;
        case ($urandom_range(0, 9))
            0:       hdr = {3'($urandom), aus_pkg::H264_TYPE_SLICE};
            1:       hdr = {3'($urandom), aus_pkg::H264_TYPE_IDR};
            2:       hdr = {3'($urandom), aus_pkg::H264_TYPE_SEI};
            3:       hdr = aus_pkg::H265_HDR_TRAIL;
            4:       hdr = aus_pkg::H265_HDR_IDR;
            5:       hdr = 8'($urandom);
            6: begin
                // noise
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
                return;
            end
            7: begin
                // broken start code
                repeat ($urandom_range(1, 2)) send_byte(aus_pkg::SC_ZERO);
                send_byte($urandom_range(0, 1) ? aus_pkg::SC_ONE
                                               : 8'($urandom_range(2, 255)));
                return;
            end
            default: hdr = $urandom_range(0, 1) ? {3'($urandom), aus_pkg::H264_TYPE_SLICE}
                                                : aus_pkg::H265_HDR_TRAIL;
        endcase
        send_start_code(hdr);
        len = $urandom_range(0, 24);
        repeat (len) send_byte($urandom_range(0, 5) == 0 ? aus_pkg::SC_ZERO : 8'($urandom));
    endtask

    // output side: random stalls, bursts without stalls, one long hold-off on request
    initial begin : result_side
        int gap;
        int pops;
        bit rx_burst;
        pops     = 0;
        rx_burst = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = rx_burst ? 0 : $urandom_range(0, 18);
            if (rx_hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            pops++;
            if (pops % 40 == 0) rx_burst = ($urandom_range(0, 2) == 0);
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("annexb_access_unit_splitter_tb: FAIL");
        $finish;
    end

    initial begin : stimulus
        int phase_start;
        tx_burst    = 1'b0;
        rx_hold_req = 1'b0;
        bytes_sent  = 0;
        directed_bytes = '{
            8'hFF, aus_pkg::SC_ZERO,
            aus_pkg::SC_ZERO, aus_pkg::SC_ZERO, aus_pkg::SC_ZERO, aus_pkg::SC_ZERO,
            aus_pkg::SC_ONE, {3'b011, aus_pkg::H264_TYPE_IDR}, 8'hFF, aus_pkg::SC_ZERO,
            aus_pkg::SC_ZERO, aus_pkg::SC_ZERO, aus_pkg::SC_ZERO, aus_pkg::SC_ONE,
            {3'b000, aus_pkg::H264_TYPE_SEI}, 8'h80,
            aus_pkg::SC_ZERO, aus_pkg::SC_ZERO, aus_pkg::SC_ZERO, aus_pkg::SC_ONE,
            {3'b111, aus_pkg::H264_TYPE_SLICE}, aus_pkg::SC_ONE,
            aus_pkg::SC_ZERO, aus_pkg::SC_ZERO, aus_pkg::SC_ZERO, aus_pkg::SC_ONE,
            {3'b010, aus_pkg::H264_TYPE_SLICE}
        };
        phase_codec = '{aus_pkg::CODEC_H264, aus_pkg::CODEC_H265, 8'h00, 8'hFF,
                        8'($urandom), aus_pkg::CODEC_H264, aus_pkg::CODEC_H265,
                        aus_pkg::CODEC_H264};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) wait_idle();
            write_codec(phase_codec[ph]);
            tx_burst = ($urandom_range(0, 3) == 0);
            if (ph == 0) begin
                foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
            end
            if (ph == 1) begin
                // back up the output until the input stalls
                tx_burst    = 1'b1;
                rx_hold_req = 1'b1;
                send_start_code(aus_pkg::H265_HDR_TRAIL);
                repeat (PRESSURE_BYTES) send_byte(8'($urandom));
                tx_burst = 1'b0;
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 15) == 0) tx_burst = ~tx_burst;
                send_random_unit();
            end
        end

        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("annexb_access_unit_splitter_tb: PASS");
        end else begin
            $display("annexb_access_unit_splitter_tb: FAIL");
        end
        $finish;
    end

endmodule
